// File: rtl/rom_page_unpack_checksum_macros.svh
// Assertion macros shared by the ROM page unpacker RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef ROM_PAGE_UNPACK_CHECKSUM_MACROS_SVH
`define ROM_PAGE_UNPACK_CHECKSUM_MACROS_SVH

// The condition holds in every cycle outside reset.
`define RPU_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rom page unpack: invariant violated");

// The consequence holds in the same cycle as the antecedent.
`define RPU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rom page unpack: same-cycle check failed");

// The consequence holds in the cycle after the antecedent.
`define RPU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rom page unpack: next-cycle check failed");

`endif

// File: rtl/rpu_pkg.sv
// Package for the ROM page unpacker: field widths, byte phase codes and the default page size.
// Depends on nothing; used by the channel interfaces and the top level.
package rpu_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 10;
    localparam int unsigned INDEX_W = 12;
    localparam int unsigned PHASE_W = 3;

    localparam int unsigned PAGE_WORDS_DEF = 4096;

    // Position of a byte inside its five-byte group.
    localparam logic [PHASE_W-1:0] PH_B0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_B1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_B2 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_B3 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_B4 = 3'd4;

    // One result transaction.
    typedef struct packed {
        logic [WORD_W-1:0]  word_value;
        logic [INDEX_W-1:0] word_index;
        logic               last_of_page;
        logic [WORD_W-1:0]  computed_checksum;
        logic               checksum_ok;
    } t_out_item;

endpackage

// File: rtl/rpu_in_if.sv
// Input channel of the ROM page unpacker: valid/ready handshake carrying one packed byte.
// Depends on rpu_pkg.
interface rpu_in_if;
    import rpu_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packed_byte;

    modport source (output valid, output packed_byte, input ready);
    modport sink (input valid, input packed_byte, output ready);
endinterface

// File: rtl/rpu_out_if.sv
// Output channel of the ROM page unpacker: valid/ready handshake carrying one unpacked word.
// Depends on rpu_pkg.
interface rpu_out_if;
    import rpu_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  word_value;
    logic [INDEX_W-1:0] word_index;
    logic               last_of_page;
    logic [WORD_W-1:0]  computed_checksum;
    logic               checksum_ok;

    modport source (output valid, output word_value, output word_index,
                    output last_of_page, output computed_checksum,
                    output checksum_ok, input ready);
    modport sink (input valid, input word_value, input word_index,
                  input last_of_page, input computed_checksum,
                  input checksum_ok, output ready);
endinterface

// File: rtl/rom_page_unpack_checksum.sv
// Top level of the ROM page unpacker with end-around-carry checksum.
// Depends on rpu_pkg, rpu_in_if, rpu_out_if and rom_page_unpack_checksum_macros.svh.
//
// Usage:
//   i_in carries packed bytes of a page image, five bytes per four 10-bit words,
//   least significant bits first. A transaction is taken when valid and ready are high.
//   o_out carries one unpacked word per byte that completes a word: its value, its
//   index in the page, a last-of-page flag and, on the last word, the two's
//   complement of the end-around-carry sum of the earlier words with a match flag.
//   The first byte of each five-byte group produces no output transaction.
// Timing and throughput:
//   A result appears on o_out in the cycle after the byte that completes it is taken.
//   One byte is accepted every cycle while o_out is not stalled; the unpack and the
//   10-bit add with carry sit between the state registers and the single output register.
// Reset:
//   i_rst_n is synchronous and active low; it clears the byte phase, leftover bits,
//   word counter, running sum and the output valid flag.
// Stalls:
//   While a result waits and o_out.ready is low, i_in.ready drops and the held
//   result stays unchanged; when the receiver takes it, a new byte is taken the same cycle.
module rom_page_unpack_checksum #(
    parameter int unsigned PAGE_WORDS = rpu_pkg::PAGE_WORDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rpu_in_if.sink          i_in,
    rpu_out_if.source       o_out
);
    import rpu_pkg::*;

    localparam int unsigned CntW = $clog2(PAGE_WORDS);
    localparam logic [CntW-1:0] LastIdx = CntW'(PAGE_WORDS - 1);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_left, n_left;
    logic [CntW-1:0]    r_count, n_count;
    logic [WORD_W-1:0]  r_sum, n_sum;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               accept;
    logic               emit;
    logic [WORD_W-1:0]  word;
    logic               last;
    logic [WORD_W:0]    sum_raw;
    logic [WORD_W-1:0]  chk;
    logic [CntW+INDEX_W-1:0] count_ext;

    // Input is taken when the output register is empty or being drained.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Unpack the current byte against the leftover bits of the previous one.
    always_comb begin
        word    = '0;
        n_left  = r_left;
        n_phase = r_phase;
        emit    = 1'b1;
        case (r_phase)
            PH_B0: begin
                n_left  = i_in.packed_byte;
                n_phase = PH_B1;
                emit    = 1'b0;
            end
            PH_B1: begin
                word    = {i_in.packed_byte[1:0], r_left};
                n_left  = {2'b00, i_in.packed_byte[7:2]};
                n_phase = PH_B2;
            end
            PH_B2: begin
                word    = {i_in.packed_byte[3:0], r_left[5:0]};
                n_left  = {4'b0000, i_in.packed_byte[7:4]};
                n_phase = PH_B3;
            end
            PH_B3: begin
                word    = {i_in.packed_byte[5:0], r_left[3:0]};
                n_left  = {6'b000000, i_in.packed_byte[7:6]};
                n_phase = PH_B4;
            end
            default: begin
                word    = {i_in.packed_byte, r_left[1:0]};
                n_left  = '0;
                n_phase = PH_B0;
            end
        endcase
    end

    // Checksum arithmetic: add with end-around carry and two's complement.
    assign last      = (r_count == LastIdx);
    assign sum_raw   = {1'b0, r_sum} + {1'b0, word};
    assign chk       = (~r_sum) + WORD_W'(1);
    assign count_ext = {{INDEX_W{1'b0}}, r_count};

    // Next state and next result.
    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        if (accept) begin
            n_out_valid              = emit;
            n_out.word_value         = word;
            n_out.word_index         = count_ext[INDEX_W-1:0];
            n_out.last_of_page       = last;
            n_out.computed_checksum  = '0;
            n_out.checksum_ok        = 1'b0;
            if (emit) begin
                if (last) begin
                    n_out.computed_checksum = chk;
                    n_out.checksum_ok       = (chk == word);
                    n_count                 = '0;
                    n_sum                   = '0;
                end else begin
                    n_sum   = sum_raw[WORD_W-1:0] + WORD_W'(sum_raw[WORD_W]);
                    n_count = r_count + CntW'(1);
                end
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_B0;
            r_left      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_phase <= (emit && last) ? PH_B0 : n_phase;
                r_left  <= (emit && last) ? '0 : n_left;
                r_count <= n_count;
                r_sum   <= n_sum;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.word_value        = r_out.word_value;
    assign o_out.word_index        = r_out.word_index;
    assign o_out.last_of_page      = r_out.last_of_page;
    assign o_out.computed_checksum = r_out.computed_checksum;
    assign o_out.checksum_ok       = r_out.checksum_ok;

    // Checks on phase sequencing, page wrap and the checksum fields.
`include "rom_page_unpack_checksum_macros.svh"

    `RPU_ASSERT_ALWAYS(a_phase_range, r_phase <= PH_B4)
    `RPU_ASSERT_NEXT(a_group_start, accept && r_phase == PH_B0, r_phase == PH_B1 && !r_out_valid)
    `RPU_ASSERT_NEXT(a_page_wrap, accept && r_phase != PH_B0 && last, r_count == '0 && r_sum == '0 && r_phase == PH_B0)
    `RPU_ASSERT_SAME(a_chk_zero, r_out_valid && !r_out.last_of_page, r_out.computed_checksum == '0 && !r_out.checksum_ok)

endmodule

// File: sim/rom_page_word_checker.sv
// Checker for the ROM page unpacker: watches both channels, predicts every word transaction
// and compares it field by field. Depends on rpu_pkg, rpu_in_if and rpu_out_if.
`timescale 1ns / 100ps

module rom_page_word_checker #(
    parameter int unsigned PAGE_WORDS = rpu_pkg::PAGE_WORDS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rpu_in_if    i_byte_ch,
    rpu_out_if   i_word_ch,
    output int   o_fail_count,
    output int   o_pending
);
    import rpu_pkg::*;

    // Mirror of the unpacker state.
    logic [PHASE_W-1:0] phase;
    logic [BYTE_W-1:0]  leftover;
    int unsigned        word_count;
    logic [WORD_W-1:0]  page_sum;

    // Words still due on the output channel, oldest first.
    t_out_item expected_words[$];
    int        fail_count = 0;
    int        pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Ten-bit add where a carry out of the top bit wraps around into bit zero.
    function automatic logic [WORD_W-1:0] add_end_around(input logic [WORD_W-1:0] a,
                                                         input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = a + b;
        if (s[WORD_W]) begin
            s = s[WORD_W-1:0] + 1'b1;
        end
        return s[WORD_W-1:0];
    endfunction

    task automatic clear_page();
        phase      = PH_B0;
        leftover   = '0;
        word_count = 0;
        page_sum   = '0;
    endtask

    // Take one accepted byte and queue the word that it completes, if any.
    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        t_out_item          item;
        logic [WORD_W-1:0]  w;
        logic [PHASE_W-1:0] start_phase;
        item        = '0;
        w           = '0;
        start_phase = phase;
        case (phase)
            PH_B0: begin
                leftover = b;
                phase    = PH_B1;
            end
            PH_B1: begin
                w        = {b[1:0], leftover};
                leftover = {2'b00, b[7:2]};
                phase    = PH_B2;
            end
            PH_B2: begin
                w        = {b[3:0], leftover[5:0]};
                leftover = {4'h0, b[7:4]};
                phase    = PH_B3;
            end
            PH_B3: begin
                w        = {b[5:0], leftover[3:0]};
                leftover = {6'h00, b[7:6]};
                phase    = PH_B4;
            end
            default: begin
                w        = {b, leftover[1:0]};
                leftover = '0;
                phase    = PH_B0;
            end
        endcase

        // The first byte of a group only loads the leftover bits.
        if (start_phase != PH_B0) begin
            item.word_value   = w;
            item.word_index   = word_count[INDEX_W-1:0];
            item.last_of_page = (word_count >= PAGE_WORDS - 1);
            if (item.last_of_page) begin
                item.computed_checksum = -page_sum;
                item.checksum_ok       = (item.computed_checksum == w);
                clear_page();
            end else begin
                page_sum = add_end_around(page_sum, w);
                word_count++;
            end
            expected_words.push_back(item);
        end
    endtask

    task automatic compare_field(input string name, input logic [INDEX_W-1:0] want_v,
                                 input logic [INDEX_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, actual %0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    // Match one word transaction against the oldest prediction.
    task automatic check_word();
        t_out_item want;
        if (expected_words.size() == 0) begin
            $error("word transaction with nothing expected: value %0h, index %0d",
                   i_word_ch.word_value, i_word_ch.word_index);
            fail_count++;
        end else begin
            want = expected_words.pop_front();
            compare_field("word_value", want.word_value, i_word_ch.word_value);
            compare_field("word_index", want.word_index, i_word_ch.word_index);
            compare_field("last_of_page", want.last_of_page, i_word_ch.last_of_page);
            compare_field("computed_checksum", want.computed_checksum,
                          i_word_ch.computed_checksum);
            compare_field("checksum_ok", want.checksum_ok, i_word_ch.checksum_ok);
        end
    endtask

    // Sample both channels at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_page();
            expected_words.delete();
        end else begin
            if (i_word_ch.valid && i_word_ch.ready) begin
                check_word();
            end
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                absorb_byte(i_byte_ch.packed_byte);
            end
        end
        pending_count = expected_words.size();
    end

endmodule

// File: sim/testbench.sv
// Top of the ROM page unpacker testbench: clock, reset, byte stimulus and output stalls.
// Depends on rpu_pkg, the channel interfaces, the block and rom_page_word_checker.
`timescale 1ns / 100ps

module testbench;
    import rpu_pkg::*;

    // The block runs at its default page size; the run stays inside the first page.
    localparam int unsigned PAGE_WORDS = PAGE_WORDS_DEF;
    localparam int          RUN_BYTES  = 440;

    typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} t_fill;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    rpu_in_if  byte_ch ();
    rpu_out_if word_ch ();

    rom_page_unpack_checksum #(
        .PAGE_WORDS(PAGE_WORDS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (byte_ch),
        .o_out  (word_ch)
    );

    rom_page_word_checker #(
        .PAGE_WORDS(PAGE_WORDS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_ch   (byte_ch),
        .i_word_ch   (word_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #2 i_clk = ~i_clk;

    int                bytes_sent;
    bit                calm;
    int                stall_left = 0;
    int                stall_len;

    // Idle length: mostly none, often short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return WORD_W'($urandom);
    endfunction

    // Receiver side: random stalls, none during calm stretches.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            word_ch.ready <= 1'b0;
        end else begin
            stall_len = calm ? 0 : idle_len();
            if (stall_len > 0) begin
                stall_left    <= stall_len - 1;
                word_ch.ready <= 1'b0;
            end else begin
                word_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one byte, hold it until taken, then maybe idle.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        byte_ch.valid       <= 1'b1;
        byte_ch.packed_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        bytes_sent++;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Pack words least significant bit first and send the bytes; a count that is a
    // multiple of four fills whole bytes.
    task automatic send_words(input t_fill how, input int count);
        logic [WORD_W-1:0] w;
        logic [23:0]       acc;
        int                nbits;
        acc   = '0;
        nbits = 0;
        for (int i = 0; i < count; i++) begin
            case (how)
                FILL_ZERO: w = '0;
                FILL_ONES: w = '1;
                default:   w = pick_word();
            endcase
            acc   = acc | (24'(w) << nbits);
            nbits = nbits + WORD_W;
            while (nbits >= BYTE_W) begin
                send_byte(acc[7:0]);
                acc   = acc >> BYTE_W;
                nbits = nbits - BYTE_W;
            end
        end
    endtask

    initial begin
        int r;
        byte_ch.valid       <= 1'b0;
        byte_ch.packed_byte <= '0;
        i_rst_n             <= 1'b0;
        calm       = 1'b0;
        bytes_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed runs: all-zero words, all-ones words and a run of all-ones bytes.
        send_words(FILL_ZERO, 8);
        send_words(FILL_ONES, 8);
        repeat (10) send_byte(8'hFF);

        // Random words in group-sized runs, plus bursts of noise bytes.
        while (bytes_sent < RUN_BYTES) begin
            calm = ($urandom_range(0, 4) == 0);
            r    = $urandom_range(0, 99);
            if (r < 85) begin
                send_words(FILL_RANDOM, 4 * $urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
            end
        end
        byte_ch.valid <= 1'b0;

        // Drain the outstanding words, then give the block a few more cycles.
        @(posedge i_clk);
        wait (pending == 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: rom_page_unpack_checksum.f
+incdir+rtl
rtl/rpu_pkg.sv
rtl/rpu_in_if.sv
rtl/rpu_out_if.sv
rtl/rom_page_unpack_checksum.sv
sim/rom_page_word_checker.sv
sim/testbench.sv
